/* rtl/core/svm_pkg.sv */
// Shared types, register indexes, clip limits and arithmetic helpers for the stereo volume mixer.
package svm_pkg;

  // One input word: a channel sample with its volumes and frame markers.
  typedef struct packed {
    logic               start_frame;
    logic signed [23:0] base_left;
    logic signed [23:0] base_right;
    logic signed [15:0] sample_value;
    logic               wide_sample;
    logic [9:0]         left_volume;
    logic [9:0]         right_volume;
    logic               channel_active;
    logic               end_frame;
  } svm_in_t;

  // One output word: a formatted frame.
  typedef struct packed {
    logic [15:0] left_code;
    logic [15:0] right_code;
    logic        right_present;
  } svm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mac;
    logic emit;
  } svm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic end_frame;
    logic out_free;
  } svm_status_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MASTER_VOLUME = 2'd0;
  localparam logic [1:0] CFG_SIXTEEN_BIT   = 2'd1;
  localparam logic [1:0] CFG_STEREO        = 2'd2;

  localparam int CFG_DATA_W = 9;
  localparam int GAIN_W     = 17;

  localparam logic [8:0] MASTER_CAP = 9'd256;
  localparam logic [8:0] MASTER_RST = 9'd256;
  localparam logic [7:0] VOL_CAP    = 8'd255;

  localparam logic signed [23:0] UPPER_STEREO16 = 24'sh007ddd;
  localparam logic signed [23:0] UPPER_OTHER    = 24'sh007fff;
  localparam logic signed [23:0] LOWER_ALL      = -24'sd32768;

  // Per-side gain: saturated volume times capped master. The 8-bit path
  // drops the low three volume bits.
  function automatic logic [GAIN_W-1:0] calc_gain(input logic [9:0] vol,
                                                  input logic       wide,
                                                  input logic [8:0] master);
    logic [7:0] vsat;
    logic [7:0] veff;
    vsat = (vol > {2'b00, VOL_CAP}) ? VOL_CAP : vol[7:0];
    veff = wide ? vsat : {vsat[7:3], 3'b000};
    return GAIN_W'(veff * master);
  endfunction

  // Shift a sum down by 8, clip it and format it as a 16-bit or 8-bit code.
  function automatic logic [15:0] format_code(input logic signed [31:0] sum,
                                              input logic              stereo16,
                                              input logic              sixteen);
    logic signed [23:0] val;
    logic signed [23:0] upper;
    val   = sum[31:8];
    upper = stereo16 ? UPPER_STEREO16 : UPPER_OTHER;
    if (val > upper) begin
      val = upper;
    end else if (val < LOWER_ALL) begin
      val = LOWER_ALL;
    end
    if (sixteen) begin
      return val[15:0];
    end
    // Offset binary byte: high byte of the clipped value plus 128.
    return {8'h00, ~val[15], val[14:8]};
  endfunction

endpackage

/* rtl/core/svm_ctrl.sv */
// Controller state machine that sequences capture, multiply-accumulate and frame emit.
module svm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  svm_pkg::svm_status_t status,
  output svm_pkg::svm_cmd_t    cmd
);
  import svm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Commands are decoded from the current state.
  assign in_stall    = (state != ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && in_valid;
  assign cmd.mac     = (state == ST_MAC);
  assign cmd.emit    = (state == ST_EMIT) && status.out_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MAC;
      end
      ST_MAC: begin
        state_next = status.end_frame ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/svm_datapath.sv */
// Datapath: configuration registers, gain stage, multiply-accumulate, clip and output register.
module svm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [svm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  svm_pkg::svm_in_t              in_word,
  input  svm_pkg::svm_cmd_t             cmd,
  output svm_pkg::svm_status_t          status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output svm_pkg::svm_out_t             out_word
);
  import svm_pkg::*;

  logic [8:0] master_volume;
  logic       output_sixteen_bit;
  logic       output_stereo;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume      <= MASTER_RST;
      output_sixteen_bit <= 1'b1;
      output_stereo      <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MASTER_VOLUME: master_volume      <= cfg_data;
        CFG_SIXTEEN_BIT:   output_sixteen_bit <= cfg_data[0];
        CFG_STEREO:        output_stereo      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [8:0] master_cap;
  assign master_cap = (master_volume > MASTER_CAP) ? MASTER_CAP : master_volume;

  // Captured word and the two gains, computed as the word is accepted.
  logic               start_frame;
  logic signed [23:0] base_left;
  logic signed [23:0] base_right;
  logic signed [15:0] sample_value;
  logic               wide_sample;
  logic               channel_active;
  logic               end_frame;
  logic [GAIN_W-1:0]  gain_left;
  logic [GAIN_W-1:0]  gain_right;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      start_frame    <= in_word.start_frame;
      base_left      <= in_word.base_left;
      base_right     <= in_word.base_right;
      sample_value   <= in_word.sample_value;
      wide_sample    <= in_word.wide_sample;
      channel_active <= in_word.channel_active;
      end_frame      <= in_word.end_frame;
      gain_left      <= calc_gain(in_word.left_volume, in_word.wide_sample, master_cap);
      gain_right     <= calc_gain(in_word.right_volume, in_word.wide_sample, master_cap);
    end
  end

  // Sample times gain; the 16-bit path is floored by 8 bits.
  logic signed [15:0] samp_ext;
  logic signed [33:0] prod_left;
  logic signed [33:0] prod_right;
  logic signed [33:0] shr_left;
  logic signed [33:0] shr_right;
  logic [31:0]        contrib_left;
  logic [31:0]        contrib_right;

  assign samp_ext   = wide_sample ? sample_value : {{8{sample_value[7]}}, sample_value[7:0]};
  assign prod_left  = 34'(samp_ext * $signed({1'b0, gain_left}));
  assign prod_right = 34'(samp_ext * $signed({1'b0, gain_right}));
  assign shr_left   = prod_left >>> 8;
  assign shr_right  = prod_right >>> 8;

  always_comb begin
    if (!channel_active) begin
      contrib_left  = '0;
      contrib_right = '0;
    end else if (wide_sample) begin
      contrib_left  = shr_left[31:0];
      contrib_right = shr_right[31:0];
    end else begin
      contrib_left  = prod_left[31:0];
      contrib_right = prod_right[31:0];
    end
  end

  // Accumulators, loaded from the base pair at the start of a frame.
  logic [31:0] left_sum;
  logic [31:0] right_sum;
  logic [31:0] acc_base_left;
  logic [31:0] acc_base_right;

  assign acc_base_left  = start_frame ? 32'(base_left) : left_sum;
  assign acc_base_right = start_frame ? 32'(base_right) : right_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum  <= '0;
      right_sum <= '0;
    end else if (cmd.mac) begin
      left_sum  <= acc_base_left + contrib_left;
      right_sum <= acc_base_right + contrib_right;
    end
  end

  // Output register: holds the frame until the consumer takes it.
  logic stereo16;
  assign stereo16 = output_sixteen_bit && output_stereo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.left_code <= format_code(left_sum, stereo16, output_sixteen_bit);
      if (output_stereo) begin
        out_word.right_code    <= format_code(right_sum, stereo16, output_sixteen_bit);
        out_word.right_present <= 1'b1;
      end else begin
        out_word.right_code    <= '0;
        out_word.right_present <= 1'b0;
      end
    end
  end

  assign status.end_frame = end_frame;
  assign status.out_free  = !out_valid || !out_stall;

endmodule

/* rtl/core/stereo_volume_mixer.sv */
// Top level of the stereo volume mixer: controller plus datapath.
//
// Each input word carries one channel's sample and its left and right volumes.
// A word is accepted in the idle state, where the two volume-by-master gains
// are formed and registered with it; in the MAC state the sample is multiplied
// by those gains and added into the left and right accumulators (loaded from
// the base pair when start_frame is set). A word with end_frame set then goes
// through the emit state, in which the sums are shifted down, clipped,
// formatted and placed in the output register; that state waits only if the
// previous frame is still held there. No word is accepted outside the idle
// state. Configuration is written through cfg_write, cfg_index and cfg_data.
module stereo_volume_mixer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  svm_pkg::svm_in_t              in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output svm_pkg::svm_out_t             out_word,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [svm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import svm_pkg::*;

  svm_cmd_t    cmd;
  svm_status_t status;

  // Sequencer.
  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  svm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the stereo volume mixer: directed frames, register settings and random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import svm_pkg::*;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  svm_in_t               in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  svm_out_t              out_word;
  logic                  cfg_write = 1'b0;
  logic [1:0]            cfg_index = CFG_MASTER_VOLUME;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the mixer's registers and accumulators.
  logic [8:0]  master_reg = MASTER_RST;
  logic        sixteen_reg = 1'b1;
  logic        stereo_reg = 1'b1;
  logic [31:0] left_acc = '0;
  logic [31:0] right_acc = '0;

  svm_out_t expected_frames[$];
  int       failures = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  stereo_volume_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run must end well before this even with the heaviest stalling.
  initial begin
    #5_000_000;
    $display("stereo_volume_mixer test failed");
    $finish;
  end

  // One channel's contribution to one side, before it is added to the sum.
  function automatic longint channel_contribution(input logic signed [15:0] smp,
                                                  input logic               wide,
                                                  input logic [9:0]         vol);
    longint v;
    longint m;
    v = (vol > 10'd255) ? 64'd255 : longint'(vol);
    m = (master_reg > MASTER_CAP) ? 64'd256 : longint'(master_reg);
    if (wide) begin
      return (longint'(smp) * v * m) >>> 8;
    end
    // Narrow samples use the low byte and a volume with its low three bits dropped.
    return longint'($signed(smp[7:0])) * ((v >>> 3) * 8 * m);
  endfunction

  // Shift an accumulator down, clip it and format it for the current output mode.
  function automatic logic [15:0] frame_code(input logic [31:0] acc, input logic stereo16);
    longint val;
    longint upper;
    val = longint'($signed(acc)) >>> 8;
    upper = stereo16 ? UPPER_STEREO16 : UPPER_OTHER;
    if (val > upper) begin
      val = upper;
    end else if (val < LOWER_ALL) begin
      val = LOWER_ALL;
    end
    if (sixteen_reg) begin
      return val[15:0];
    end
    return {8'h00, 8'((val >>> 8) + 128)};
  endfunction

  // Advance the mirrored accumulators by one accepted word and queue any frame it emits.
  task automatic mix_word(input svm_in_t w);
    svm_out_t f;
    logic     st16;
    if (w.start_frame) begin
      left_acc = {{8{w.base_left[23]}}, w.base_left};
      right_acc = {{8{w.base_right[23]}}, w.base_right};
    end
    if (w.channel_active) begin
      left_acc = left_acc + 32'(channel_contribution(w.sample_value, w.wide_sample,
                                                     w.left_volume));
      right_acc = right_acc + 32'(channel_contribution(w.sample_value, w.wide_sample,
                                                       w.right_volume));
    end
    if (w.end_frame) begin
      st16 = sixteen_reg && stereo_reg;
      f.left_code = frame_code(left_acc, st16);
      if (stereo_reg) begin
        f.right_code = frame_code(right_acc, st16);
        f.right_present = 1'b1;
      end else begin
        f.right_code = '0;
        f.right_present = 1'b0;
      end
      expected_frames.push_back(f);
    end
  endtask

  function automatic svm_in_t word_of(input logic st, input logic [23:0] bl,
                                      input logic [23:0] br, input logic [15:0] smp,
                                      input logic wide, input logic [9:0] lv,
                                      input logic [9:0] rv, input logic act,
                                      input logic fin);
    svm_in_t w;
    w.start_frame = st;
    w.base_left = bl;
    w.base_right = br;
    w.sample_value = smp;
    w.wide_sample = wide;
    w.left_volume = lv;
    w.right_volume = rv;
    w.channel_active = act;
    w.end_frame = fin;
    return w;
  endfunction

  // Volumes cluster around the saturation point and the small end now and then.
  function automatic logic [9:0] pick_volume();
    case ($urandom_range(3))
      0: return 10'($urandom);
      1: return 10'($urandom_range(255));
      2: return 10'($urandom_range(263, 248));
      default: return 10'($urandom_range(31));
    endcase
  endfunction

  function automatic svm_in_t random_word(input logic st, input logic fin);
    return word_of(st, 24'($urandom), 24'($urandom), 16'($urandom), 1'($urandom),
                   pick_volume(), pick_volume(), $urandom_range(99) < 85, fin);
  endfunction

  // Present one word, hold it until the mixer takes it, then update the prediction.
  task automatic send_word(input svm_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    mix_word(w);
  endtask

  // Stop sending and wait until every frame has come out and the datapath has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_MASTER_VOLUME: master_reg = data;
      CFG_SIXTEEN_BIT:   sixteen_reg = data[0];
      CFG_STEREO:        stereo_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic [8:0] master, input logic sixteen, input logic stereo);
    wait_idle();
    write_reg(CFG_MASTER_VOLUME, master);
    write_reg(CFG_SIXTEEN_BIT, CFG_DATA_W'(sixteen));
    write_reg(CFG_STEREO, CFG_DATA_W'(stereo));
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare every frame the mixer delivers with the oldest prediction.
  always @(posedge clk) begin
    svm_out_t exp_frame;
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected frame: left_code %h right_code %h right_present %b",
               out_word.left_code, out_word.right_code, out_word.right_present);
        failures++;
      end else begin
        exp_frame = expected_frames.pop_front();
        if (out_word.left_code !== exp_frame.left_code) begin
          $error("left_code: expected %h, got %h", exp_frame.left_code, out_word.left_code);
          failures++;
        end
        if (out_word.right_code !== exp_frame.right_code) begin
          $error("right_code: expected %h, got %h", exp_frame.right_code, out_word.right_code);
          failures++;
        end
        if (out_word.right_present !== exp_frame.right_present) begin
          $error("right_present: expected %b, got %b", exp_frame.right_present,
                 out_word.right_present);
          failures++;
        end
      end
    end
  end

  // Extremes of the fields with the reset settings: 16-bit stereo at full master.
  task automatic test_field_extremes();
    send_word(word_of(1, 24'h000000, 24'h000000, 16'h0000, 1, 10'd0, 10'd0, 0, 1));
    send_word(word_of(1, 24'h7fffff, 24'h800000, 16'h1234, 1, 10'd255, 10'd255, 0, 1));
    send_word(word_of(1, 24'h000000, 24'h000000, 16'h7fff, 1, 10'd1023, 10'd0, 1, 1));
    send_word(word_of(1, 24'h7fffff, 24'h7fffff, 16'h8000, 1, 10'd255, 10'd256, 1, 1));
    // Narrow samples: only the low byte counts, and volumes below 8 add nothing.
    send_word(word_of(1, 24'h000100, 24'hffff00, 16'h7f80, 0, 10'd7, 10'd8, 1, 1));
    send_word(word_of(1, 24'h000000, 24'h000000, 16'h807f, 0, 10'd255, 10'd1023, 1, 1));
    send_word(word_of(1, 24'hfff000, 24'h001000, 16'hffff, 0, 10'd512, 10'd15, 1, 1));
    // A multi-word frame, then a restart in the middle of a frame.
    send_word(word_of(1, 24'h012345, 24'hfedcba, 16'h0400, 1, 10'd100, 10'd200, 1, 0));
    send_word(word_of(0, 24'h7fffff, 24'h7fffff, 16'hfc00, 1, 10'd50, 10'd60, 1, 0));
    send_word(word_of(0, 24'h000000, 24'h000000, 16'h0040, 0, 10'd255, 10'd128, 1, 1));
    send_word(word_of(0, 24'h000000, 24'h000000, 16'h0100, 1, 10'd64, 10'd64, 1, 0));
    send_word(word_of(1, 24'h000800, 24'h000800, 16'h0100, 1, 10'd64, 10'd64, 1, 0));
    // An inactive word still emits the frame on end.
    send_word(word_of(0, 24'h000000, 24'h000000, 16'h7fff, 1, 10'd255, 10'd255, 0, 1));
  endtask

  // Master above the cap, master zero, mono and the 8-bit offset output.
  task automatic test_output_modes();
    set_mode(9'd511, 1'b1, 1'b1);
    send_word(word_of(1, 24'h000000, 24'h000000, 16'h2000, 1, 10'd255, 10'd40, 1, 1));
    set_mode(9'd300, 1'b1, 1'b1);
    send_word(word_of(1, 24'h000000, 24'h000000, 16'h0011, 0, 10'd255, 10'd40, 1, 1));
    set_mode(9'd0, 1'b1, 1'b0);
    send_word(word_of(1, 24'h7fffff, 24'h800000, 16'h7fff, 1, 10'd255, 10'd255, 1, 1));
    set_mode(9'd256, 1'b1, 1'b0);
    send_word(word_of(1, 24'h000000, 24'h000000, 16'h7fff, 1, 10'd255, 10'd255, 1, 1));
    set_mode(9'd256, 1'b0, 1'b1);
    send_word(word_of(1, 24'h7fffff, 24'h800000, 16'h0000, 1, 10'd0, 10'd0, 0, 1));
    send_word(word_of(1, 24'h000000, 24'h000000, 16'hff81, 0, 10'd255, 10'd9, 1, 1));
    set_mode(9'd128, 1'b0, 1'b0);
    send_word(word_of(1, 24'hff0000, 24'h010000, 16'hc000, 1, 10'd255, 10'd255, 1, 1));
    set_mode(MASTER_RST, 1'b1, 1'b1);
  endtask

  // Drive the left accumulator past the signed 32-bit range so it wraps around.
  task automatic test_accumulator_wrap();
    send_word(word_of(1, 24'h7fffff, 24'h800000, 16'h7fff, 1, 10'd255, 10'd64, 1, 0));
    repeat (300) begin
      send_word(word_of(0, 24'h000000, 24'h000000, 16'h7fff, 1, 10'd255, 10'd64, 1, 0));
    end
    send_word(word_of(0, 24'h000000, 24'h000000, 16'h8000, 1, 10'd255, 10'd1023, 1, 1));
  endtask

  // Random frames with random content, with noise words mixed in, across settings and idling.
  task automatic test_random_traffic();
    int sent;
    int len;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 6)
        0: set_mode(9'd256, 1'b1, 1'b1);
        1: set_mode(9'd0, 1'b1, 1'b0);
        2: set_mode(9'd511, 1'b0, 1'b1);
        3: set_mode(9'd1, 1'b0, 1'b0);
        4: set_mode(9'd128, 1'b1, 1'b1);
        default: set_mode(9'd300, 1'b1, 1'b0);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      sent = 0;
      while (sent < 125) begin
        if ($urandom_range(9) == 0) begin
          send_word(random_word(1'($urandom), 1'($urandom)));
          sent++;
        end else begin
          len = $urandom_range(5, 1);
          for (int i = 0; i < len; i++) begin
            send_word(random_word((i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                                  i == len - 1));
            sent++;
          end
        end
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_output_modes();
    test_accumulator_wrap();
    test_random_traffic();
    wait_idle();
    if (failures == 0) begin
      $display("stereo_volume_mixer test passed");
    end else begin
      $display("stereo_volume_mixer test failed");
    end
    $finish;
  end

endmodule
